>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define VSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define VSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/vsf_pkg.sv
// Shared constants and the gradient function of the seam finder.
package vsf_pkg;

  localparam int SIZE_W         = 7;
  localparam int PIX_W          = 24;
  localparam int CUM_W          = 32;
  localparam int GRAD_W         = 18;
  localparam int ENERGY_W       = 19;
  localparam int OUT_POS_W      = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  // Sum of squared channel differences of two RGB pixels.
  function automatic logic [GRAD_W-1:0] grad(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        d;
    logic [GRAD_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      x   = a[8*k +: 8];
      y   = b[8*k +: 8];
      d   = (x > y) ? (x - y) : (y - x);
      acc = acc + GRAD_W'(16'(d) * 16'(d));
    end
    return acc;
  endfunction

endpackage

>>> sv/vsf_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
module vsf_ram #(
  parameter int AW = 12,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/vertical_seam_finder.sv
// Top level: image load, energy pass, bottom-row search and seam backtrack.
// Pixels load at one item per cycle into the pixel RAM. The item that completes
// the image starts the seam pass, during which pixel_stall_o is high: for each pixel
// the energy pass makes four neighbor reads on the single pixel RAM port, and parent
// reads and a write-back on the cumulative RAM; a bottom-row minimum search follows,
// and each seam row takes backtrack reads, with each item issued when the output is
// free. Seam items leave bottom row first; seam_last_o marks row 0.
// The next image may load while the final seam item still waits downstream.
module vertical_seam_finder #(
  parameter int MAX_WIDTH  = vsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = vsf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pixel_valid_i,
  output logic                               pixel_stall_o,
  input  logic [vsf_pkg::PIX_W-1:0]          pixel_rgb_i,
  output logic                               seam_valid_o,
  input  logic                               seam_stall_i,
  output logic [vsf_pkg::OUT_POS_W-1:0]      seam_row_o,
  output logic [vsf_pkg::OUT_POS_W-1:0]      seam_column_o,
  output logic                               seam_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vsf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vsf_pkg::SIZE_W-1:0]         cfg_data_i
);
  import vsf_pkg::*;

  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_EN   = 3'd1;
  localparam logic [2:0] ST_FIND = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_BT   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [2:0]          step_q, step_d;
  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic [SIZE_W-1:0]   w_q, w_d, h_q, h_d;
  logic [PIX_W-1:0]    pl_q, pl_d, pu_q, pu_d;
  logic [ENERGY_W-1:0] e_q, e_d;
  logic [CUM_W-1:0]    m_q, m_d, best_q, best_d, cl_q, cl_d, cm_q, cm_d;
  logic [CW-1:0]       bcol_q, bcol_d, fidx_q, fidx_d;
  logic                iss_q, iss_d, fv_q, fv_d;
  logic                sv_q, sv_d, slast_q, slast_d;
  logic [OUT_POS_W-1:0] srow_q, srow_d, scol_q, scol_d;

  logic [SIZE_W-1:0] wc, hc;
  logic              col_last, row_last;
  logic [CW-1:0]     col_m1, col_p1, cl, cr;
  logic [RW-1:0]     row_m1, row_p1, ru, rdn, hm1;
  logic              pix_we, cum_we;
  logic [AW-1:0]     pix_waddr, pix_raddr, cum_waddr, cum_raddr;
  logic [PIX_W-1:0]  pix_rd;
  logic [CUM_W-1:0]  cum_rd, cum_wdata;
  logic              out_free, pix_acc, better;
  logic [CW-1:0]     bsel;

  function automatic logic [AW-1:0] addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(32'(r) * MAX_WIDTH + 32'(c));
  endfunction

  assign wc = (w_q < SIZE_W'(2)) ? SIZE_W'(2) :
              (w_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : w_q;
  assign hc = (h_q < SIZE_W'(2)) ? SIZE_W'(2) :
              (h_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : h_q;

  assign col_last = SIZE_W'(col_q) == (wc - SIZE_W'(1));
  assign row_last = SIZE_W'(row_q) == (hc - SIZE_W'(1));
  assign col_m1   = col_q - CW'(1);
  assign col_p1   = col_q + CW'(1);
  assign row_m1   = row_q - RW'(1);
  assign row_p1   = row_q + RW'(1);
  assign hm1      = RW'(hc - SIZE_W'(1));
  // wrapping neighbors
  assign cl  = (col_q == '0) ? CW'(wc - SIZE_W'(1)) : col_m1;
  assign cr  = col_last ? '0 : col_p1;
  assign ru  = (row_q == '0) ? hm1 : row_m1;
  assign rdn = row_last ? '0 : row_p1;

  assign pixel_stall_o = state_q != ST_LOAD;
  assign cfg_ready_o   = 1'b1;
  assign pix_acc       = pixel_valid_i && !pixel_stall_o;
  assign out_free      = !sv_q || !seam_stall_i;

  assign pix_we    = pix_acc;
  assign pix_waddr = addr(row_q, col_q);
  assign cum_we    = (state_q == ST_EN) && (step_q == 3'd5);
  assign cum_waddr = addr(row_q, col_q);
  assign cum_wdata = CUM_W'(e_q) + ((row_q == '0) ? '0 : m_q);

  always_comb begin
    case (step_q)
      3'd0:    pix_raddr = addr(row_q, cl);
      3'd1:    pix_raddr = addr(row_q, cr);
      3'd2:    pix_raddr = addr(ru, col_q);
      default: pix_raddr = addr(rdn, col_q);
    endcase
  end

  always_comb begin
    if (state_q == ST_FIND) begin
      cum_raddr = addr(hm1, col_q);
    end else if (state_q == ST_BT) begin
      case (step_q)
        3'd0:    cum_raddr = addr(row_q, col_m1);
        3'd1:    cum_raddr = addr(row_q, col_q);
        default: cum_raddr = addr(row_q, col_p1);
      endcase
    end else begin
      case (step_q)
        3'd0:    cum_raddr = addr(row_m1, col_m1);
        3'd1:    cum_raddr = addr(row_m1, col_q);
        default: cum_raddr = addr(row_m1, col_p1);
      endcase
    end
  end

  assign better = (fidx_q == '0) || (cum_rd < best_q);
  assign bsel   = better ? fidx_q : bcol_q;

  always_comb begin
    state_d = state_q; step_d = step_q; row_d = row_q; col_d = col_q;
    w_d = w_q; h_d = h_q; pl_d = pl_q; pu_d = pu_q; e_d = e_q; m_d = m_q;
    best_d = best_q; cl_d = cl_q; cm_d = cm_q; bcol_d = bcol_q; fidx_d = fidx_q;
    iss_d = iss_q; fv_d = fv_q;
    sv_d = sv_q && seam_stall_i;
    srow_d = srow_q; scol_d = scol_q; slast_d = slast_q;

    case (state_q)
      ST_LOAD: begin
        if (pix_acc) begin
          if (col_last) begin
            col_d = '0;
            if (row_last) begin
              row_d   = '0;
              step_d  = 3'd0;
              state_d = ST_EN;
            end else begin
              row_d = row_p1;
            end
          end else begin
            col_d = col_p1;
          end
        end
      end
      ST_EN: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd1: begin
            pl_d = pix_rd;
            m_d  = (col_q != '0) ? cum_rd : '1;
          end
          3'd2: begin
            e_d = ENERGY_W'(grad(pl_q, pix_rd));
            if (cum_rd < m_q) m_d = cum_rd;
          end
          3'd3: begin
            pu_d = pix_rd;
            if (!col_last && cum_rd < m_q) m_d = cum_rd;
          end
          3'd4: begin
            e_d = e_q + ENERGY_W'(grad(pu_q, pix_rd));
          end
          3'd5: begin
            step_d = 3'd0;
            if (col_last) begin
              col_d = '0;
              if (row_last) begin
                state_d = ST_FIND;
                iss_d   = 1'b1;
                fv_d    = 1'b0;
              end else begin
                row_d = row_p1;
              end
            end else begin
              col_d = col_p1;
            end
          end
          default: ;
        endcase
      end
      ST_FIND: begin
        fv_d = iss_q;
        if (iss_q) begin
          fidx_d = col_q;
          if (col_last) iss_d = 1'b0;
          else col_d = col_p1;
        end
        if (fv_q) begin
          bcol_d = bsel;
          if (better) best_d = cum_rd;
          if (SIZE_W'(fidx_q) == (wc - SIZE_W'(1))) begin
            state_d = ST_EMIT;
            row_d   = hm1;
            col_d   = bsel;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          sv_d    = 1'b1;
          srow_d  = OUT_POS_W'(row_q);
          scol_d  = OUT_POS_W'(col_q);
          slast_d = row_q == '0;
          if (row_q == '0) begin
            col_d   = '0;
            state_d = ST_LOAD;
          end else begin
            row_d   = row_m1;
            step_d  = 3'd0;
            state_d = ST_BT;
          end
        end
      end
      ST_BT: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd1: cl_d = cum_rd;
          3'd2: cm_d = cum_rd;
          3'd3: begin
            state_d = ST_EMIT;
            if (col_q == '0) begin
              if (!(cm_q < cum_rd)) col_d = CW'(1);
            end else if (col_last) begin
              if (cl_q < cm_q) col_d = col_m1;
            end else if (cl_q < cm_q && cl_q < cum_rd) begin
              col_d = col_m1;
            end else if (!(cm_q < cum_rd)) begin
              col_d = col_p1;
            end
          end
          default: ;
        endcase
      end
      default: state_d = ST_LOAD;
    endcase

    // the user must write only while idle; the block does not enforce it; a valid register write restarts loading
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_WIDTH) begin
        w_d = cfg_data_i; row_d = '0; col_d = '0;
      end else if (cfg_index_i == CFG_HEIGHT) begin
        h_d = cfg_data_i; row_d = '0; col_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      w_q     <= SIZE_W'(64);
      h_q     <= SIZE_W'(64);
      iss_q   <= 1'b0;
      fv_q    <= 1'b0;
      sv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      row_q   <= row_d;
      col_q   <= col_d;
      w_q     <= w_d;
      h_q     <= h_d;
      iss_q   <= iss_d;
      fv_q    <= fv_d;
      sv_q    <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q    <= pl_d;
    pu_q    <= pu_d;
    e_q     <= e_d;
    m_q     <= m_d;
    best_q  <= best_d;
    cl_q    <= cl_d;
    cm_q    <= cm_d;
    bcol_q  <= bcol_d;
    fidx_q  <= fidx_d;
    srow_q  <= srow_d;
    scol_q  <= scol_d;
    slast_q <= slast_d;
  end

  vsf_ram #(.AW(AW), .DW(PIX_W)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pixel_rgb_i),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rd)
  );

  vsf_ram #(.AW(AW), .DW(CUM_W)) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (cum_we),
    .waddr_i (cum_waddr),
    .wdata_i (cum_wdata),
    .raddr_i (cum_raddr),
    .rdata_o (cum_rd)
  );

  assign seam_valid_o  = sv_q;
  assign seam_row_o    = srow_q;
  assign seam_column_o = scol_q;
  assign seam_last_o   = slast_q;

endmodule

>>> sv/vsf_checker.sv
// Port-level checker for the seam finder, bound to the top level.
`include "assert_macros.svh"

module vsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pixel_stall_o,
  input logic       seam_valid_o,
  input logic       seam_stall_i,
  input logic [5:0] seam_row_o,
  input logic [5:0] seam_column_o,
  input logic       seam_last_o
);

  // a waiting seam item holds
  `VSF_ASSERT_NEXT(a_hold, clk_i, rst_ni, seam_valid_o && seam_stall_i, $stable(seam_column_o) && $stable(seam_row_o))
  // end-of-seam flag only on row 0, and row 0 is always the end
  `VSF_ASSERT_IMPL(a_last_row, clk_i, rst_ni, seam_valid_o, seam_last_o == (seam_row_o == 6'd0))
  // mid-seam the loader stays closed until the final item has been issued
  `VSF_ASSERT_NEXT(a_busy, clk_i, rst_ni, seam_valid_o && !seam_stall_i && !seam_last_o, pixel_stall_o || seam_valid_o)

endmodule

bind vertical_seam_finder vsf_checker u_vsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pixel_stall_o (pixel_stall_o),
  .seam_valid_o  (seam_valid_o),
  .seam_stall_i  (seam_stall_i),
  .seam_row_o    (seam_row_o),
  .seam_column_o (seam_column_o),
  .seam_last_o   (seam_last_o)
);

>>> test/tb_vertical_seam_finder.sv
// Testbench for vertical_seam_finder: image loads checked against a seam predictor.
`timescale 1ns / 1ps

module tb_vertical_seam_finder;
  import vsf_pkg::*;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] column;
    logic                 last;
  } seam_entry_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 pixel_valid_i = 1'b0;
  logic                 pixel_stall_o;
  logic [PIX_W-1:0]     pixel_rgb_i = '0;
  logic                 seam_valid_o;
  logic                 seam_stall_i = 1'b0;
  logic [OUT_POS_W-1:0] seam_row_o;
  logic [OUT_POS_W-1:0] seam_column_o;
  logic                 seam_last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i = '0;

  vertical_seam_finder DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0]  img_pix [4096];
  int unsigned       img_cum [4096];
  logic [11:0]       pix_count;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  seam_entry_t       seam_q [$];

  int  err_count = 0;
  int  mismatch_count = 0;
  bit  idle_on = 1'b1;
  int  hold_left = 0;
  int  burst_left = 0;
  int  items_sent = 0;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic int unsigned color_grad(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    int unsigned acc;
    int          d;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      d   = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
      acc += d * d;
    end
    return acc;
  endfunction

  function automatic int unsigned cum_at(int unsigned r, int unsigned c);
    return img_cum[(r * 64 + c) % 4096];
  endfunction

  function automatic logic [PIX_W-1:0] pix_at(int unsigned r, int unsigned c);
    return img_pix[(r * 64 + c) % 4096];
  endfunction

  function automatic void trace_seam(int unsigned w, int unsigned h);
    int unsigned e, m, col, best, r;
    int unsigned lv, mv, rv;
    seam_entry_t ent;
    for (int unsigned rr = 0; rr < h; rr++) begin
      for (int unsigned c = 0; c < w; c++) begin
        e = color_grad(pix_at(rr, (c + w - 1) % w), pix_at(rr, (c + 1) % w)) +
            color_grad(pix_at((rr + h - 1) % h, c), pix_at((rr + 1) % h, c));
        if (rr > 0) begin
          m = cum_at(rr - 1, c);
          if (c > 0 && cum_at(rr - 1, c - 1) < m) m = cum_at(rr - 1, c - 1);
          if (c + 1 < w && cum_at(rr - 1, c + 1) < m) m = cum_at(rr - 1, c + 1);
          e += m;
        end
        img_cum[rr * 64 + c] = e;
      end
    end
    col  = 0;
    best = cum_at(h - 1, 0);
    for (int unsigned c = 1; c < w; c++)
      if (cum_at(h - 1, c) < best) begin
        best = cum_at(h - 1, c);
        col  = c;
      end
    r = h - 1;
    forever begin
      ent.row    = OUT_POS_W'(r);
      ent.column = OUT_POS_W'(col);
      ent.last   = (r == 0);
      seam_q.push_back(ent);
      if (r == 0) break;
      r--;
      if (col == 0) begin
        if (!(cum_at(r, 0) < cum_at(r, 1))) col = 1;
      end else if (col == w - 1) begin
        if (cum_at(r, col - 1) < cum_at(r, col)) col = col - 1;
      end else begin
        lv = cum_at(r, col - 1);
        mv = cum_at(r, col);
        rv = cum_at(r, col + 1);
        if (lv < mv && lv < rv) col = col - 1;
        else if (!(mv < rv)) col = col + 1;
      end
    end
  endfunction

  function automatic void predict_pixel(logic [PIX_W-1:0] p);
    int unsigned w, h, r, c;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    r = pix_count / w;
    c = pix_count % w;
    if (r < 64) img_pix[r * 64 + c] = p;
    pix_count = pix_count + 1'b1;
    if (pix_count == 0 || pix_count >= w * h) begin
      pix_count = '0;
      trace_seam(w, h);
    end
  endfunction

  // sender: called at a falling edge, returns at a falling edge
  task automatic send_pixel(logic [PIX_W-1:0] p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pixel_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_rgb_i   <= p;
    do @(posedge clk_i); while (pixel_stall_o);
    predict_pixel(p);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_pixels();
    pixel_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (seam_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WIDTH) width_reg = val;
    else height_reg = val;
    pix_count = '0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(CFG_WIDTH, SIZE_W'(w));
    write_reg(CFG_HEIGHT, SIZE_W'(h));
  endtask

  // mode 0: full random, 1: small palette (forces ties), 2: constant
  task automatic send_image(int unsigned n, int mode);
    logic [PIX_W-1:0] p;
    p = $urandom();
    for (int unsigned i = 0; i < n; i++) begin
      if (mode == 0) p = $urandom();
      else if (mode == 1) p = {3{8'($urandom_range(0, 2))}};
      send_pixel(p);
    end
    stop_pixels();
  endtask

  task automatic test_smallest_image();
    set_size(2, 2);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    send_pixel(24'h123456);
    send_pixel(24'hEDCBA9);
    stop_pixels();
  endtask

  task automatic test_ties();
    set_size(4, 3);
    send_image(12, 2);
    set_size(5, 3);
    send_image(15, 1);
  endtask

  task automatic test_size_clamp();
    write_reg(CFG_WIDTH, 7'd0);
    write_reg(CFG_HEIGHT, 7'd1);
    send_image(4, 0);
    write_reg(CFG_WIDTH, 7'd127);
    write_reg(CFG_HEIGHT, 7'd2);
    send_image(128, 0);
  endtask

  task automatic test_restart();
    set_size(3, 3);
    send_image(4, 0);
    write_reg(CFG_WIDTH, 7'd3);
    send_image(9, 0);
  endtask

  task automatic test_random();
    int unsigned w, h;
    while (items_sent < 215) begin
      if (items_sent > 195) idle_on = 1'b0;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 8) : $urandom_range(2, 5);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 8) : $urandom_range(2, 5);
      set_size(w, h);
      if ($urandom_range(0, 7) == 0) begin
        // abandoned image, then a full one
        send_image($urandom_range(1, w * h - 1), 0);
        write_reg(CFG_HEIGHT, SIZE_W'(h));
      end
      repeat ($urandom_range(1, 2)) send_image(w * h, $urandom_range(0, 3) == 0);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_size(2, 3);
    hold_left = 300;
    send_image(6 * 2, 0);
    wait_drained();
  endtask

  initial begin
    pix_count  = '0;
    width_reg  = 7'd64;
    height_reg = 7'd64;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_smallest_image();
    test_ties();
    test_size_clamp();
    test_restart();
    test_backpressure();
    test_random();
    wait_drained();
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver stall: a long hold-off when one is set, else random bursts
  initial forever begin
    @(negedge clk_i);
    if (hold_left > 0) begin
      hold_left--;
      seam_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      seam_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 14);
      seam_stall_i <= 1'b1;
    end else begin
      seam_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    seam_entry_t want;
    if (rst_ni && seam_valid_o && !seam_stall_i) begin
      if (seam_q.size() == 0) begin
        err_count++;
        if (mismatch_count++ < 10)
          $display("unexpected seam item row %0d col %0d last %0b",
                   seam_row_o, seam_column_o, seam_last_o);
      end else begin
        want = seam_q.pop_front();
        if (want.row !== seam_row_o || want.column !== seam_column_o ||
            want.last !== seam_last_o) begin
          err_count++;
          if (mismatch_count++ < 10)
            $display("seam mismatch: expected row %0d col %0d last %0b, got %0d %0d %0b",
                     want.row, want.column, want.last,
                     seam_row_o, seam_column_o, seam_last_o);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
